// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the score priority pairing queue: entry
// layout, result codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_W        = 16;
  localparam int SCORE_W     = 32;
  localparam int ARR_W       = 32;
  localparam int GAP_W       = 32;
  localparam int COUNT_OUT_W = 5;

  localparam int S_TDATA_W   = ID_W + SCORE_W;                  // 48, whole bytes
  localparam int M_COUNT_LSB = 2 * ID_W;
  localparam int M_TDATA_W   = 40;
  localparam int M_PAD_W     = M_TDATA_W - 2 * ID_W - COUNT_OUT_W;

  localparam logic [GAP_W-1:0] GAP_RESET = 32'd1000000;

  localparam logic MODE_ENTER = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_FEW    = 2'd2,
    ST_NOPART = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic [ARR_W-1:0]          arrival;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENT_CHK,
    S_ENT_RD,
    S_ENT_EV,
    S_ENT_PUT,
    S_MAT_CHK,
    S_MAT_WAIT,
    S_MAT_HEAD,
    S_MAT_RD,
    S_MAT_EV,
    S_MAT_SEL,
    S_CMP_RD,
    S_CMP_EV,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    ent_begin;
    logic    ent_step;
    logic    ent_put0;
    logic    mat_begin;
    logic    mat_head;
    logic    mat_step;
    logic    cmp_begin;
    logic    cmp_step;
    logic    res_load;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic few;
    logic cnt_zero;
    logic ent_less;
    logic idx_zero;
    logic idx_last;
    logic hit_hi;
    logic found_any;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the pairing queue: walks the entry memory for insertion,
// partner search and compaction, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic mode,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (mode == MODE_MATCH) ? S_MAT_CHK : S_ENT_CHK;
        end
      end
      S_ENT_CHK: begin
        if (sts.full) state_next = S_RESP;
        else if (sts.cnt_zero) state_next = S_ENT_PUT;
        else state_next = S_ENT_RD;
      end
      S_ENT_RD:  state_next = S_ENT_EV;
      S_ENT_EV: begin
        if (!sts.ent_less) state_next = S_RESP;
        else if (sts.idx_zero) state_next = S_ENT_PUT;
        else state_next = S_ENT_RD;
      end
      S_ENT_PUT:  state_next = S_RESP;
      S_MAT_CHK:  state_next = sts.few ? S_RESP : S_MAT_WAIT;
      S_MAT_WAIT: state_next = S_MAT_HEAD;
      S_MAT_HEAD: state_next = S_MAT_RD;
      S_MAT_RD:   state_next = S_MAT_EV;
      S_MAT_EV: begin
        state_next = (sts.hit_hi || sts.idx_last) ? S_MAT_SEL : S_MAT_RD;
      end
      S_MAT_SEL:  state_next = sts.found_any ? S_CMP_RD : S_RESP;
      S_CMP_RD:   state_next = S_CMP_EV;
      S_CMP_EV:   state_next = sts.idx_last ? S_RESP : S_CMP_RD;
      S_RESP:     state_next = sts.out_free ? S_IDLE : S_RESP;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_code = ST_DONE;
    case (state)
      S_IDLE:    cmd.load_item = s_tvalid;
      S_ENT_CHK: begin
        if (sts.full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
        end else begin
          cmd.ent_begin = 1'b1;
        end
      end
      S_ENT_EV:  cmd.ent_step = 1'b1;
      S_ENT_PUT: cmd.ent_put0 = 1'b1;
      S_MAT_CHK: begin
        if (sts.few) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FEW;
        end else begin
          cmd.mat_begin = 1'b1;
        end
      end
      S_MAT_HEAD: cmd.mat_head = 1'b1;
      S_MAT_EV:   cmd.mat_step = 1'b1;
      S_MAT_SEL: begin
        if (sts.found_any) begin
          cmd.cmp_begin = 1'b1;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOPART;
        end
      end
      S_CMP_EV: cmd.cmp_step = 1'b1;
      S_RESP:   cmd.out_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== hdl/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Datapath for the pairing queue: sorted entry memory, count and arrival
// registers, scan pointers, compare logic and the output register.
// ----------------------------------------------------------------------------
module spq_dp
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [S_TDATA_W-1:0]   s_tdata,
  input  logic                   cfg_valid,
  input  logic [GAP_W-1:0]       cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,
  output logic [1:0]             m_tuser,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  logic [CW-1:0]             count;
  logic [ARR_W-1:0]          next_arrival;
  logic [GAP_W-1:0]          gap;

  logic [ID_W-1:0]           new_id;
  logic signed [SCORE_W-1:0] new_score;
  logic [ARR_W-1:0]          new_arr;
  logic [ID_W-1:0]           head_id;
  logic signed [SCORE_W-1:0] head_score;
  logic [CW-1:0]             idx;
  logic [AW-1:0]             dst;
  logic [AW-1:0]             pick;
  logic                      hi_found, lo_found;
  logic [AW-1:0]             hi_pos, lo_pos;
  status_t                   res_code;
  logic [ID_W-1:0]           res_fid, res_sid;

  entry_t                    new_entry;
  logic                      ent_less;
  logic                      id_ok, cond_hi, cond_lo;
  logic signed [SCORE_W:0]   diff;
  logic                      we;
  logic [AW-1:0]             wa;
  entry_t                    wd;

  assign new_entry = '{id: new_id, score: new_score, arrival: new_arr};

  // entry sorts after the new one: lower score, or same score and older
  assign ent_less = (rd_q.score < new_score) ||
                    ((rd_q.score == new_score) && (rd_q.arrival < new_arr));

  assign id_ok   = (rd_q.id != head_id);
  assign diff    = {head_score[SCORE_W-1], head_score} - {rd_q.score[SCORE_W-1], rd_q.score};
  assign cond_hi = id_ok && (rd_q.score >= head_score);
  assign cond_lo = id_ok && !diff[SCORE_W] && (diff != '0) && (diff[SCORE_W-1:0] < gap);

  always_comb begin
    sts.full      = (count == CW'(QUEUE_DEPTH));
    sts.few       = (count < CW'(2));
    sts.cnt_zero  = (count == '0);
    sts.ent_less  = ent_less;
    sts.idx_zero  = (idx == '0);
    sts.idx_last  = (idx == count - CW'(1));
    sts.hit_hi    = cond_hi;
    sts.found_any = hi_found || lo_found;
    sts.out_free  = !m_tvalid || m_tready;
  end

  // single write port: insertion shift, new entry, or compaction move
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rd_q;
    if (cmd.ent_step) begin
      we = 1'b1;
      wa = idx[AW-1:0] + AW'(1);
      wd = ent_less ? rd_q : new_entry;
    end else if (cmd.ent_put0) begin
      we = 1'b1;
      wd = new_entry;
    end else if (cmd.cmp_step && (idx[AW-1:0] != pick)) begin
      we = 1'b1;
      wa = dst;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      next_arrival <= '0;
      gap          <= GAP_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) gap <= cfg_data;
      if (cmd.ent_begin) next_arrival <= next_arrival + ARR_W'(1);
      if ((cmd.ent_step && !ent_less) || cmd.ent_put0) count <= count + CW'(1);
      if (cmd.cmp_step && sts.idx_last) count <= count - CW'(2);
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      new_id    <= s_tdata[ID_W-1:0];
      new_score <= s_tdata[S_TDATA_W-1:ID_W];
      res_code  <= ST_DONE;
      res_fid   <= '0;
      res_sid   <= '0;
    end
    if (cmd.res_load) res_code <= cmd.res_code;
    if (cmd.ent_begin) begin
      new_arr <= next_arrival;
      idx     <= count - CW'(1);
    end
    if (cmd.ent_step && ent_less) idx <= idx - CW'(1);
    if (cmd.mat_begin) idx <= '0;
    if (cmd.mat_head) begin
      head_id    <= rd_q.id;
      head_score <= rd_q.score;
      idx        <= CW'(1);
      hi_found   <= 1'b0;
      lo_found   <= 1'b0;
    end
    if (cmd.mat_step) begin
      if (cond_hi) begin
        hi_found <= 1'b1;
        hi_pos   <= idx[AW-1:0];
      end
      if (cond_lo && !lo_found) begin
        lo_found <= 1'b1;
        lo_pos   <= idx[AW-1:0];
      end
      idx <= idx + CW'(1);
    end
    if (cmd.cmp_begin) begin
      pick    <= hi_found ? hi_pos : lo_pos;
      res_fid <= head_id;
      idx     <= CW'(1);
      dst     <= '0;
    end
    if (cmd.cmp_step) begin
      if (idx[AW-1:0] == pick) res_sid <= rd_q.id;
      else dst <= dst + AW'(1);
      idx <= idx + CW'(1);
    end
    if (cmd.out_load) begin
      m_tdata <= {{M_PAD_W{1'b0}}, COUNT_OUT_W'(count), res_sid, res_fid};
      m_tuser <= res_code;
    end
  end

endmodule

// ===== hdl/score_priority_pairing_queue_core.sv =====
// ----------------------------------------------------------------------------
// score_priority_pairing_queue_core
// Bounded priority queue of requesters sorted by score, with pairing.
// ----------------------------------------------------------------------------
// One item is handled at a time; its result lands in an output register so
// the next item is accepted while that result waits. An enter item steps
// through the queued entries that sort behind the new one; a pairing reads
// the head, scans for a partner and then runs a compaction pass, and each
// entry visit is a registered memory read. A full queue, or fewer than two
// queued for a pairing, gives a status with no walk, and with no partner
// the compaction pass is skipped. A result still waiting in the output
// register holds the next one back before s_tready rises again.
// The gap register may be written whenever the queue is idle; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module score_priority_pairing_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] user_id, [47:16] score
  input  logic                 s_tuser,   // [0] mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] first_id, [31:16] second_id,
                                          // [36:32] count_after, [39:37] zero
  output logic [1:0]           m_tuser,   // [1:0] status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [GAP_W-1:0]     cfg_data   // max_lower_gap
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hdl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the pairing queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  localparam logic [COUNT_OUT_W-1:0] DEPTH_OUT = COUNT_OUT_W'(QUEUE_DEPTH);

  logic [COUNT_OUT_W-1:0] cnt_out;
  logic [ID_W-1:0]        fid, sid;

  assign fid     = m_tdata[ID_W-1:0];
  assign sid     = m_tdata[2*ID_W-1:ID_W];
  assign cnt_out = m_tdata[M_COUNT_LSB +: COUNT_OUT_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one transaction in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // failed items report no ids
  a_fail_ids: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> (fid == '0) && (sid == '0))
    else $error("ids reported on a failed item");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL) |-> (cnt_out == DEPTH_OUT))
    else $error("full status with queue not full");

  a_few_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FEW) |-> (cnt_out < COUNT_OUT_W'(2)))
    else $error("too-few status with two or more queued");

endmodule

bind score_priority_pairing_queue_core spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== test/score_priority_pairing_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// score_priority_pairing_queue_core_tb
// Sends enter and pairing requests through the stream ports and keeps its own
// copy of the sorted queue, so that it can work out the status, ids and count
// of every result. Results are checked in order. The run goes through several
// gap settings and through sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module score_priority_pairing_queue_core_tb;
  import spq_pkg::*;

  localparam int QUEUE_SLOTS = 16;

  typedef struct packed {
    logic                      mode;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } request_t;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        first_id;
    logic [ID_W-1:0]        second_id;
    logic [COUNT_OUT_W-1:0] count_after;
  } outcome_t;

  class pairing_queue_mirror;
    logic [ID_W-1:0] ids [QUEUE_SLOTS];
    int              scores [QUEUE_SLOTS];
    int unsigned     arrivals [QUEUE_SLOTS];
    int unsigned     count;
    int unsigned     next_arrival;
    longint          lower_gap;
    outcome_t        due_outcomes [$];
    int              errors;

    function new();
      count        = 0;
      next_arrival = 0;
      lower_gap    = {32'd0, GAP_RESET};
      errors       = 0;
    endfunction

    function void set_gap(logic [GAP_W-1:0] v);
      lower_gap = {32'd0, v};
    endfunction

    function int pending();
      return due_outcomes.size();
    endfunction

    function void drop_entry(int unsigned pos);
      for (int unsigned i = pos; i + 1 < count; i++) begin
        ids[i]      = ids[i + 1];
        scores[i]   = scores[i + 1];
        arrivals[i] = arrivals[i + 1];
      end
      count--;
    endfunction

    function void note_request(request_t r);
      outcome_t        o;
      int unsigned     pos;
      int unsigned     pick;
      int              sc;
      longint          head_score;
      longint          diff;
      logic [ID_W-1:0] head_id;
      bit              found;
      o        = '0;
      o.status = ST_DONE;
      sc       = r.score;
      if (r.mode == MODE_ENTER) begin
        if (count >= QUEUE_SLOTS) begin
          o.status = ST_FULL;
        end else begin
          // skip entries that stay ahead: higher score, or same score and newer
          pos = 0;
          while (pos < count && (scores[pos] > sc ||
                 (scores[pos] == sc && arrivals[pos] >= next_arrival)))
            pos++;
          for (int unsigned i = count; i > pos; i--) begin
            ids[i]      = ids[i - 1];
            scores[i]   = scores[i - 1];
            arrivals[i] = arrivals[i - 1];
          end
          ids[pos]      = r.id;
          scores[pos]   = sc;
          arrivals[pos] = next_arrival;
          next_arrival++;
          count++;
        end
      end else if (count < 2) begin
        o.status = ST_FEW;
      end else begin
        head_id    = ids[0];
        head_score = scores[0];
        found      = 0;
        pick       = 0;
        for (int unsigned i = 1; i < count && !found; i++) begin
          if (ids[i] != head_id && scores[i] >= head_score) begin
            pick  = i;
            found = 1;
          end
        end
        // lower partner: gap strictly between zero and the register, in 64 bits
        for (int unsigned i = 1; i < count && !found; i++) begin
          diff = head_score - scores[i];
          if (ids[i] != head_id && diff > 0 && diff < lower_gap) begin
            pick  = i;
            found = 1;
          end
        end
        if (!found) begin
          o.status = ST_NOPART;
        end else begin
          o.first_id  = head_id;
          o.second_id = ids[pick];
          drop_entry(pick);
          drop_entry(0);
        end
      end
      o.count_after = COUNT_OUT_W'(count);
      due_outcomes.push_back(o);
    endfunction

    function void check_outcome(logic [M_TDATA_W-1:0] data, logic [1:0] code);
      outcome_t want;
      if (due_outcomes.size() == 0) begin
        $display("%0t: unexpected result, status %0d tdata %h", $time, code, data);
        errors++;
        return;
      end
      want = due_outcomes.pop_front();
      if (code !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, code);
        errors++;
      end
      if (data[ID_W-1:0] !== want.first_id) begin
        $display("%0t: first_id expected %0d got %0d", $time, want.first_id,
                 data[ID_W-1:0]);
        errors++;
      end
      if (data[2*ID_W-1:ID_W] !== want.second_id) begin
        $display("%0t: second_id expected %0d got %0d", $time, want.second_id,
                 data[2*ID_W-1:ID_W]);
        errors++;
      end
      if (data[M_COUNT_LSB +: COUNT_OUT_W] !== want.count_after) begin
        $display("%0t: count_after expected %0d got %0d", $time, want.count_after,
                 data[M_COUNT_LSB +: COUNT_OUT_W]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [15:0] user_id, [47:16] score
  logic                 s_tuser;   // [0] mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;   // [15:0] first_id, [31:16] second_id,
                                   // [36:32] count_after, [39:37] zero
  logic [1:0]           m_tuser;   // [1:0] status
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [GAP_W-1:0]     cfg_data;

  int                   send_idle_pct;
  int                   recv_stall_pct;
  pairing_queue_mirror  mirror;

  score_priority_pairing_queue_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // result side: check each transaction, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_outcome(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic request_t make_request(logic mode, logic [ID_W-1:0] id,
                                            logic [SCORE_W-1:0] score);
    request_t r;
    r.mode  = mode;
    r.id    = id;
    r.score = score;
    return r;
  endfunction

  function automatic request_t enter_request(int base, int spread);
    request_t r;
    r.mode = MODE_ENTER;
    // a handful of ids most of the time, so duplicates show up often
    r.id = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(5));
    case ($urandom_range(9))
      0:       r.score = $urandom;
      1:       r.score = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(2)
                                           : 32'h8000_0000 + $urandom_range(2);
      default: r.score = base + $urandom_range(2 * spread) - spread;
    endcase
    return r;
  endfunction

  function automatic request_t match_request();
    return make_request(MODE_MATCH, ID_W'($urandom), $urandom);
  endfunction

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.score, r.id};
    s_tuser  <= r.mode;
    do @(posedge clk); while (!s_tready);
    mirror.note_request(r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.set_gap(v);
  endtask

  // bursts of enters and pairings with random content, plus some noise
  task automatic run_phase(input int items, input int spread, input bit hold_midway);
    int sent;
    int len;
    int base;
    bit held;
    sent = 0;
    held = 0;
    while (sent < items) begin
      base = $urandom_range(2000) * 1000000 - 1000000000;
      case ($urandom_range(3))
        0, 1: begin
          len = $urandom_range(18, 1);
          for (int k = 0; k < len; k++) send_request(enter_request(base, spread));
          sent += len;
          len = $urandom_range(8, 1);
          for (int k = 0; k < len; k++) send_request(match_request());
          sent += len;
        end
        2: begin
          len = $urandom_range(10, 1);
          for (int k = 0; k < len; k++) send_request(match_request());
          sent += len;
        end
        default: begin
          len = $urandom_range(4, 1);
          for (int k = 0; k < len; k++)
            send_request($urandom_range(1) ? match_request() : enter_request(base, spread));
          sent += len;
        end
      endcase
      if (hold_midway && !held && sent >= items / 2) begin
        wait_drained();
        held = 1;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mirror         = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default gap: too few queued, duplicate ids, ties, gap boundary
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd5, 32'd100));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd5, 32'd100));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd7, 32'd100));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd9, 32'd1000099));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd9, 32'd1000100));
    send_request(make_request(MODE_ENTER, 16'd5, 32'd100));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd3, 32'd1000100));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd8, 32'd100));
    send_request(make_request(MODE_MATCH, 16'hFFFF, 32'hFFFF_FFFF));

    // widest gap against the score extremes
    wait_drained();
    write_gap(32'hFFFF_FFFF);
    send_request(make_request(MODE_ENTER, 16'd0, 32'h7FFF_FFFF));
    send_request(make_request(MODE_ENTER, 16'hFFFF, 32'h8000_0000));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));
    send_request(make_request(MODE_ENTER, 16'd1, 32'h8000_0001));
    send_request(make_request(MODE_MATCH, 16'd0, 32'd0));

    wait_drained();
    run_phase(100, 1000000000, 0);

    wait_drained();
    write_gap(32'd1);
    send_idle_pct = 57;
    run_phase(100, 3, 1);

    wait_drained();
    write_gap(GAP_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    run_phase(100, 1500000, 0);

    wait_drained();
    write_gap($urandom_range(3000000, 1));
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    run_phase(100, 2000000, 0);

    wait_drained();
    write_gap(32'd500);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(100, 400, 0);

    wait_drained();
    write_gap(32'hFFFF_FFFE);
    send_idle_pct  = 57;
    recv_stall_pct = 57;
    run_phase(100, 1000000000, 0);

    wait_drained();
    repeat (150) @(posedge clk);
    if (mirror.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
